/* hdl/hopf_to_quaternion_defines.svh */
// ----------------------------------------------------------------------------
// hopf_to_quaternion_defines.svh
// Assertion macros shared by the Hopf-to-quaternion block.
// ----------------------------------------------------------------------------
`ifndef HOPF_TO_QUATERNION_DEFINES_SVH
`define HOPF_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HQ_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HQ_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hq_pkg.sv */
// ----------------------------------------------------------------------------
// hq_pkg
// Types, widths and constants of the Hopf-to-quaternion block.
// ----------------------------------------------------------------------------
package hq_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int OUT_BITS   = 16;

  // Phase: one full turn = 2^34, quarter turn = 2^32.
  localparam int PHASE_W = 34;
  localparam int R_W     = 32;
  localparam int ARG_W   = R_W + 1;        // quarter-wave argument, 0..2^32
  localparam int X_W     = 32;             // angle in radians, Q31
  localparam int X2_W    = 33;             // x squared, Q31
  localparam int T_W     = 32;             // Horner term, Q31, at most 1.0
  localparam int FRAC    = 31;
  localparam int DIV_W   = 8;
  localparam int RECIP_W = 31;
  localparam int Q_W     = 31;

  localparam logic [ARG_W-1:0] QUARTER     = ARG_W'(1) << R_W;
  localparam logic [T_W-1:0]   Q31_ONE     = T_W'(1) << FRAC;
  localparam logic [X_W-1:0]   HALF_PI_Q31 = 32'hC90FDAA2;

  localparam int HORNER_STEPS = 7;
  localparam int CELL_STAGES  = 3;
  localparam int SINE_LATENCY = 3 + HORNER_STEPS * CELL_STAGES;

  // Divisors k*(k+1) for k = 14, 12, ..., 2 and floor(2^33 / divisor).
  localparam logic [DIV_W-1:0] HORNER_DIV [HORNER_STEPS] = '{
    8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [RECIP_W-1:0] HORNER_RECIP [HORNER_STEPS] = '{
    31'((64'd1 << 33) / 64'd210),
    31'((64'd1 << 33) / 64'd156),
    31'((64'd1 << 33) / 64'd110),
    31'((64'd1 << 33) / 64'd72),
    31'((64'd1 << 33) / 64'd42),
    31'((64'd1 << 33) / 64'd20),
    31'((64'd1 << 33) / 64'd6)
  };

  typedef struct packed {
    logic [ANGLE_BITS-1:0] polar_angle;
    logic [ANGLE_BITS-1:0] azimuth_angle;
    logic [ANGLE_BITS-1:0] fibre_angle;
  } hopf_beat_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] quat_w;
    logic signed [OUT_BITS-1:0] quat_x;
    logic signed [OUT_BITS-1:0] quat_y;
    logic signed [OUT_BITS-1:0] quat_z;
  } quat_beat_t;

  // Data handed from one Horner cell to the next.
  typedef struct packed {
    logic [X2_W-1:0] x2;
    logic [X_W-1:0]  x;
    logic [T_W-1:0]  t;
  } horner_t;

endpackage

/* hdl/hopf_to_quaternion.sv */
// ----------------------------------------------------------------------------
// hopf_to_quaternion
// Hopf coordinates (polar, azimuth, fibre binary angles) to a unit quaternion.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the skid register is empty and returns one
// quaternion beat per input beat, in order. The rate is set by the six
// quarter-wave sine lanes: each is a row of seven identical Horner cells of
// three stages each (multiply, reciprocal multiply, remainder fix), and every
// cell hands its term to the next one every cycle, so a new beat enters each
// cycle while the pipeline advances. An output register plus one skid register
// sit behind the pipeline; hopf_ready drops only while the skid register holds
// a beat, and comes back the cycle after it drains.
// Components are Q1.(OUT_BITS-1), rounded half up and saturated at +1.0.
// ----------------------------------------------------------------------------
`include "hopf_to_quaternion_defines.svh"

module hopf_to_quaternion (
  input  logic               clk,
  input  logic               rst,
  input  logic               hopf_valid,
  output logic               hopf_ready,
  input  hq_pkg::hopf_beat_t hopf,
  output logic               quat_valid,
  input  logic               quat_ready,
  output hq_pkg::quat_beat_t quat
);
  import hq_pkg::*;

  localparam int ANGLES      = 3;        // polar/2, fibre/2, azimuth+fibre/2
  localparam int LANES       = 2 * ANGLES;
  localparam int COMPS       = 4;
  localparam int PIPE_DEPTH  = SINE_LATENCY + 2;
  localparam int HALF_SHIFT  = PHASE_W - 1 - ANGLE_BITS;
  localparam int FULL_SHIFT  = PHASE_W - ANGLE_BITS;
  localparam int ROUND_SHIFT = 63 - OUT_BITS;
  localparam int WIDE_W      = 65;
  localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [WIDE_W-1:0] COMP_HI =
    (WIDE_W'(1) <<< (OUT_BITS - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] COMP_LO = -(WIDE_W'(1) <<< (OUT_BITS - 1));

  // Pipeline control: the whole pipeline moves while the skid slot is empty.
  logic                  adv;
  logic                  produce;
  logic [PIPE_DEPTH-1:0] vld;
  logic                  skid_valid;
  quat_beat_t            skid;
  quat_beat_t            result;

  assign adv        = !skid_valid;
  assign hopf_ready = adv;
  assign produce    = adv && vld[PIPE_DEPTH-1];

  // Phase formation: half angles are the input shifted one less place.
  logic [PHASE_W-1:0] phase [ANGLES];

  always_comb begin
    phase[0] = PHASE_W'(hopf.polar_angle) << HALF_SHIFT;
    phase[1] = PHASE_W'(hopf.fibre_angle) << HALF_SHIFT;
    phase[2] = (PHASE_W'(hopf.azimuth_angle) << FULL_SHIFT) + phase[1];
  end

  // Stage 0: quadrant and offset inside the quadrant.
  logic [ANGLES-1:0][1:0] quad0;
  logic [R_W-1:0]         r0 [ANGLES];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < ANGLES; a++) begin
        quad0[a] <= phase[a][PHASE_W-1 -: 2];
        r0[a]    <= phase[a][R_W-1:0];
      end
    end
  end

  // Even lane: S(r); odd lane: S(quarter - r), the quarter-wave cosine.
  logic [ARG_W-1:0] lane_arg  [LANES];
  logic [X_W-1:0]   lane_sine [LANES];

  always_comb begin
    for (int a = 0; a < ANGLES; a++) begin
      lane_arg[2*a]   = ARG_W'(r0[a]);
      lane_arg[2*a+1] = QUARTER - ARG_W'(r0[a]);
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    hq_quarter_sine u_lane (
      .clk  (clk),
      .adv  (adv),
      .arg  (lane_arg[l]),
      .sine (lane_sine[l])
    );
  end

  // Quadrants ride along with the lanes.
  logic [ANGLES-1:0][1:0] quad_pipe [SINE_LATENCY];

  always_ff @(posedge clk) begin
    if (adv) begin
      quad_pipe[0] <= quad0;
      for (int i = 1; i < SINE_LATENCY; i++) begin
        quad_pipe[i] <= quad_pipe[i-1];
      end
    end
  end

  // Quadrant folding: magnitude and sign of sine and cosine per angle.
  logic [X_W-1:0]    sin_mag [ANGLES];
  logic [X_W-1:0]    cos_mag [ANGLES];
  logic [ANGLES-1:0] sin_neg;
  logic [ANGLES-1:0] cos_neg;
  logic [1:0]        qd [ANGLES];

  always_comb begin
    for (int a = 0; a < ANGLES; a++) begin
      qd[a]      = quad_pipe[SINE_LATENCY-1][a];
      sin_mag[a] = qd[a][0] ? lane_sine[2*a+1] : lane_sine[2*a];
      cos_mag[a] = qd[a][0] ? lane_sine[2*a]   : lane_sine[2*a+1];
      sin_neg[a] = qd[a][1];
      cos_neg[a] = qd[a][1] ^ qd[a][0];
    end
  end

  // Component factors: w, x, y, z.
  logic [X_W-1:0]   fac_a [COMPS];
  logic [X_W-1:0]   fac_b [COMPS];
  logic [COMPS-1:0] fac_neg;

  always_comb begin
    fac_a[0] = cos_mag[0]; fac_b[0] = cos_mag[1]; fac_neg[0] = cos_neg[0] ^ cos_neg[1];
    fac_a[1] = cos_mag[0]; fac_b[1] = sin_mag[1]; fac_neg[1] = cos_neg[0] ^ sin_neg[1];
    fac_a[2] = sin_mag[0]; fac_b[2] = cos_mag[2]; fac_neg[2] = sin_neg[0] ^ cos_neg[2];
    fac_a[3] = sin_mag[0]; fac_b[3] = sin_mag[2]; fac_neg[3] = sin_neg[0] ^ sin_neg[2];
  end

  // Product stage: unsigned Q62 magnitudes, sign kept aside.
  logic [2*X_W-1:0] prod_mag [COMPS];
  logic [COMPS-1:0] prod_neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < COMPS; c++) begin
        prod_mag[c] <= (2*X_W)'(fac_a[c]) * (2*X_W)'(fac_b[c]);
      end
      prod_neg <= fac_neg;
    end
  end

  // Round half up to OUT_BITS-1 fraction bits, then saturate.
  logic [WIDE_W-1:0]        mag_ext [COMPS];
  logic signed [WIDE_W-1:0] biased  [COMPS];
  logic signed [WIDE_W-1:0] shifted [COMPS];
  logic [OUT_BITS-1:0]      comp    [COMPS];

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      mag_ext[c] = WIDE_W'(prod_mag[c]);
      biased[c]  = prod_neg[c] ? $signed(ROUND_HALF - mag_ext[c])
                               : $signed(mag_ext[c] + ROUND_HALF);
      shifted[c] = biased[c] >>> ROUND_SHIFT;
      if (shifted[c] > COMP_HI) begin
        comp[c] = COMP_HI[OUT_BITS-1:0];
      end else if (shifted[c] < COMP_LO) begin
        comp[c] = COMP_LO[OUT_BITS-1:0];
      end else begin
        comp[c] = shifted[c][OUT_BITS-1:0];
      end
    end
    result.quat_w = comp[0];
    result.quat_x = comp[1];
    result.quat_y = comp[2];
    result.quat_z = comp[3];
  end

  // Valid chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], hopf_valid};
    end
  end

  // Output register and skid slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (quat_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (produce) begin
      if (!quat_valid || quat_ready) begin
        quat_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (quat_ready) begin
      quat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (quat_ready) begin
        quat <= skid;
      end
    end else if (produce) begin
      if (!quat_valid || quat_ready) begin
        quat <= result;
      end else begin
        skid <= result;
      end
    end
  end

  // A finished beat meeting a stalled output goes to the skid slot.
  `HQ_ASSERT_NEXT(a_skid_fill, clk, rst, !skid_valid && produce && quat_valid && !quat_ready, skid_valid, "beat arriving at stalled output was not parked")
  // The skid slot only holds a beat behind a waiting output beat.
  `HQ_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, quat_valid, "skid holds a beat while output is empty")
  // Draining the skid slot keeps the output occupied.
  `HQ_ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && quat_ready, quat_valid && !skid_valid, "skid drain lost a beat")

endmodule

/* hdl/hq_horner_cell.sv */
// ----------------------------------------------------------------------------
// hq_horner_cell
// One Horner step of the sine series: t = 1 - (x2 * t) / (k * (k + 1)).
// ----------------------------------------------------------------------------
module hq_horner_cell (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [hq_pkg::DIV_W-1:0]    div,
  input  logic [hq_pkg::RECIP_W-1:0]  recip,
  input  hq_pkg::horner_t             up,
  output hq_pkg::horner_t             down
);
  import hq_pkg::*;

  logic [X2_W+T_W-1:0]     prod_v;
  logic [X2_W+RECIP_W-1:0] prod_q;
  logic [Q_W+DIV_W-1:0]    prod_d;
  logic [X2_W:0]           rem;
  logic [Q_W-1:0]          quo;

  // stage 1
  logic [X2_W-1:0] v1;
  logic [X2_W-1:0] x2_1;
  logic [X_W-1:0]  x_1;
  // stage 2
  logic [X2_W-1:0] v2;
  logic [Q_W-1:0]  qe2;
  logic [X2_W-1:0] x2_2;
  logic [X_W-1:0]  x_2;

  assign prod_v = (X2_W+T_W)'(up.x2) * (X2_W+T_W)'(up.t);
  assign prod_q = (X2_W+RECIP_W)'(v1) * (X2_W+RECIP_W)'(recip);
  assign prod_d = (Q_W+DIV_W)'(qe2) * (Q_W+DIV_W)'(div);

  // estimate is exact or one short; remainder stays below twice the divisor
  assign rem = (X2_W+1)'(v2) - (X2_W+1)'(prod_d);
  assign quo = qe2 + Q_W'(rem >= (X2_W+1)'(div));

  always_ff @(posedge clk) begin
    if (adv) begin
      v1     <= prod_v[FRAC+X2_W-1:FRAC];
      x2_1   <= up.x2;
      x_1    <= up.x;
      v2     <= v1;
      qe2    <= prod_q[X2_W+RECIP_W-1:33];
      x2_2   <= x2_1;
      x_2    <= x_1;
      down.x2 <= x2_2;
      down.x  <= x_2;
      down.t  <= Q31_ONE - T_W'(quo);
    end
  end

endmodule

/* hdl/hq_quarter_sine.sv */
// ----------------------------------------------------------------------------
// hq_quarter_sine
// Pipelined quarter-wave sine, argument 0..2^32 (quarter turn), result Q31.
// ----------------------------------------------------------------------------
module hq_quarter_sine (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [hq_pkg::ARG_W-1:0] arg,
  output logic [hq_pkg::X_W-1:0]   sine
);
  import hq_pkg::*;

  logic [ARG_W+X_W-1:0] prod_x;
  logic [2*X_W-1:0]     prod_sq;
  logic [X_W+T_W-1:0]   prod_s;
  logic [X_W+1:0]       s_raw;   // 33 bits of (x * t) >> 31

  logic [X_W-1:0]  x1;
  logic [X_W-1:0]  x_2;
  logic [X2_W-1:0] x2_2;

  horner_t link [HORNER_STEPS+1];

  assign prod_x  = (ARG_W+X_W)'(arg) * (ARG_W+X_W)'(HALF_PI_Q31);
  assign prod_sq = (2*X_W)'(x1) * (2*X_W)'(x1);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1   <= prod_x[2*X_W-1:X_W];
      x_2  <= x1;
      x2_2 <= prod_sq[FRAC+X2_W-1:FRAC];
    end
  end

  always_comb begin
    link[0].x2 = x2_2;
    link[0].x  = x_2;
    link[0].t  = Q31_ONE;
  end

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
    hq_horner_cell u_step (
      .clk   (clk),
      .adv   (adv),
      .div   (HORNER_DIV[i]),
      .recip (HORNER_RECIP[i]),
      .up    (link[i]),
      .down  (link[i+1])
    );
  end

  assign prod_s = (X_W+T_W)'(link[HORNER_STEPS].x) * (X_W+T_W)'(link[HORNER_STEPS].t);
  assign s_raw  = (X_W+2)'(prod_s[X_W+T_W-1:FRAC]);

  // clamp at one
  always_ff @(posedge clk) begin
    if (adv) begin
      sine <= (s_raw > (X_W+2)'(Q31_ONE)) ? Q31_ONE : s_raw[X_W-1:0];
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hopf-coordinate to quaternion converter.
// ----------------------------------------------------------------------------
// Drives (polar, azimuth, fibre) angle beats into the block and checks each
// quaternion beat against a bit-exact fixed-point model kept here: polynomial
// quarter-wave sine, quadrant folding, Q62 products rounded half up to Q1.15
// with saturation. Corner angles come first, then random points under a mix
// of sender gaps and receiver stalls, and finally a long output hold that
// backs the pipeline up into the input side.
// ----------------------------------------------------------------------------
module testbench;

  import hq_pkg::*;

  localparam int ANGLE_W = hq_pkg::ANGLE_BITS;
  localparam int QUAT_W  = hq_pkg::OUT_BITS;

  // Fixed-point constants of the angle model (Q31, one quarter turn = 2^32).
  localparam logic [63:0] Q31_UNIT     = 64'd1 << 31;
  localparam logic [63:0] HALF_PI_RAD  = 64'hC90FDAA2;
  localparam logic [63:0] TURN_QUARTER = 64'd1 << 32;
  localparam int          ROUND_SHIFT  = 63 - QUAT_W;
  localparam longint      QUAT_MAX     = (longint'(1) << (QUAT_W - 1)) - 1;
  localparam longint      QUAT_MIN     = -(longint'(1) << (QUAT_W - 1));

  localparam int CYCLE_LIMIT  = 200000;  // watchdog limit on the whole run
  localparam int HOLD_CYCLES  = 300;     // output hold during back-pressure test
  localparam int DRAIN_CYCLES = 60;      // pipeline is 26 deep plus skid
  localparam int RANDOM_BEATS = 330;     // per idle/stall mix

  // Corner points, packed as {polar, azimuth, fibre}.
  localparam int CORNER_COUNT = 20;
  localparam logic [47:0] CORNER_POINTS [CORNER_COUNT] = '{
    48'h0000_0000_0000,   // identity, w saturates at +1.0
    48'hFFFF_FFFF_FFFF,   // all ones
    48'h8000_0000_0000,   // half polar = quarter turn, y = +1.0
    48'h8000_8000_0000,   // y = -1.0, the negative full scale
    48'h8000_4000_0000,   // z = +1.0
    48'h8000_C000_0000,   // z = -1.0
    48'h0000_0000_8000,   // x = +1.0
    48'h0000_0000_4000,
    48'h0000_0000_C000,
    48'h4000_2000_4000,
    48'hFFFF_0000_0000,
    48'h0000_FFFF_0000,
    48'h0000_0000_FFFF,
    48'h8000_8000_8000,   // sum angle crosses a quadrant
    48'h8000_C000_8000,   // sum angle wraps to exactly one turn
    48'h0001_0001_0001,
    48'h7FFF_3FFF_BFFF,   // just below quadrant boundaries
    48'h8001_4001_C001,   // just above quadrant boundaries
    48'hAAAA_5555_AAAA,
    48'h5555_AAAA_5555
  };

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       hopf_valid = 1'b0;
  logic       quat_ready = 1'b0;
  hopf_beat_t hopf       = '0;
  logic       hopf_ready;
  logic       quat_valid;
  quat_beat_t quat;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  hopf_to_quaternion u_top (
    .clk        (clk),
    .rst        (rst),
    .hopf_valid (hopf_valid),
    .hopf_ready (hopf_ready),
    .hopf       (hopf),
    .quat_valid (quat_valid),
    .quat_ready (quat_ready),
    .quat       (quat)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  quat_beat_t expected_quats [$];   // predicted beats, oldest first
  int send_idle_pct = 0;            // chance per cycle that the sender idles
  int stall_pct     = 0;            // chance per cycle that the receiver stalls
  logic hold_start  = 1'b0;         // one-cycle pulse that starts a long hold
  int hold_left     = 0;
  int error_count   = 0;
  int points_sent   = 0;
  int quats_checked = 0;
  int input_stalls  = 0;            // cycles with hopf_valid high, hopf_ready low
  int cycle_count   = 0;

  // --------------------------------------------------------------------------
  // Angle model
  // --------------------------------------------------------------------------
  // Sine over a quarter turn: r in 0..2^32, result Q31, Taylor series in Horner
  // form with truncating divides, same wrap-around as 64-bit unsigned math.
  function automatic logic [63:0] quarter_wave_sine(logic [63:0] r);
    logic [63:0] x, x2, t, s;
    int k;
    x  = (r * HALF_PI_RAD) >> 32;
    x2 = (x * x) >> 31;
    t  = Q31_UNIT;
    for (k = 14; k >= 2; k -= 2)
      t = Q31_UNIT - ((x2 * t) >> 31) / 64'(k * (k + 1));
    s = (x * t) >> 31;
    return (s > Q31_UNIT) ? Q31_UNIT : s;
  endfunction

  // Full-turn phase (2^34 per turn) to signed Q31 sine and cosine.
  // Odd quadrants swap sine and cosine; the upper half negates both.
  function automatic void phase_sin_cos(input logic [33:0] phase,
                                        output longint sn, output longint cs);
    logic [63:0] r;
    longint s, c;
    r = {32'd0, phase[31:0]};
    s = longint'(quarter_wave_sine(r));
    c = longint'(quarter_wave_sine(TURN_QUARTER - r));
    sn = phase[32] ? c : s;
    cs = phase[32] ? -s : c;
    if (phase[33]) begin
      sn = -sn;
      cs = -cs;
    end
  endfunction

  // Q31 x Q31 -> Q1.15: add half an LSB, floor, saturate.
  function automatic logic signed [QUAT_W-1:0] round_product(longint a, longint b);
    logic [63:0] u;
    longint v;
    u = 64'(a * b) + (64'd1 << 62) + (64'd1 << (ROUND_SHIFT - 1));
    v = longint'(u >> ROUND_SHIFT) - longint'((64'd1 << 62) >> ROUND_SHIFT);
    if (v > QUAT_MAX) v = QUAT_MAX;
    if (v < QUAT_MIN) v = QUAT_MIN;
    return v[QUAT_W-1:0];
  endfunction

  function automatic quat_beat_t hopf_to_quat(hopf_beat_t pt);
    logic [33:0] half_polar, half_fibre, sum_phase;
    longint sp, cp, sf, cf, ss, cs;
    quat_beat_t q;
    half_polar = 34'(pt.polar_angle) << (33 - ANGLE_W);
    half_fibre = 34'(pt.fibre_angle) << (33 - ANGLE_W);
    sum_phase  = (34'(pt.azimuth_angle) << (34 - ANGLE_W)) + half_fibre;  // mod turn
    phase_sin_cos(half_polar, sp, cp);
    phase_sin_cos(half_fibre, sf, cf);
    phase_sin_cos(sum_phase, ss, cs);
    q.quat_w = round_product(cp, cf);
    q.quat_x = round_product(cp, sf);
    q.quat_y = round_product(sp, cs);
    q.quat_z = round_product(sp, ss);
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offers one beat, idling first at the current rate. Valid is only lowered
  // when an idle cycle is taken, so back-to-back beats keep it high.
  task automatic send_point(hopf_beat_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      hopf_valid <= 1'b0;
      @(posedge clk);
    end
    hopf_valid <= 1'b1;
    hopf       <= pt;
    do @(posedge clk); while (!hopf_ready);
    // accepted at this edge; result cannot appear before the next one
    expected_quats.push_back(hopf_to_quat(pt));
    points_sent++;
  endtask

  // Mostly uniform angles, with some landing right on a quadrant boundary
  // (+/- 2 LSB) where the sine folding changes.
  function automatic logic [ANGLE_W-1:0] random_angle();
    logic [ANGLE_W-1:0] a;
    a = ANGLE_W'($urandom);
    if ($urandom_range(7) == 0)
      a = {a[ANGLE_W-1 -: 2], {(ANGLE_W-2){1'b0}}} + ANGLE_W'($urandom_range(4))
          - ANGLE_W'(2);
    return a;
  endfunction

  task automatic send_random_points(int count);
    hopf_beat_t pt;
    repeat (count) begin
      pt.polar_angle   = random_angle();
      pt.azimuth_angle = random_angle();
      pt.fibre_angle   = random_angle();
      send_point(pt);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------
  // Hold counter: runs on its own so the sender can keep pushing meanwhile.
  always @(posedge clk) begin
    if (hold_start)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst || hold_start || hold_left != 0)
      quat_ready <= 1'b0;
    else
      quat_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(string fname, logic [QUAT_W-1:0] want,
                             logic [QUAT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname,
               $signed(want), $signed(got));
      error_count++;
    end
  endtask

  // Every quaternion beat is matched against the oldest prediction.
  always @(posedge clk) begin : check_quat
    quat_beat_t want;
    if (!rst && quat_valid && quat_ready) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected quaternion beat, expected none, got %h",
                 $time, quat);
        error_count++;
      end else begin
        want = expected_quats.pop_front();
        check_field("quat_w", want.quat_w, quat.quat_w);
        check_field("quat_x", want.quat_x, quat.quat_x);
        check_field("quat_y", want.quat_y, quat.quat_y);
        check_field("quat_z", want.quat_z, quat.quat_z);
        quats_checked++;
      end
    end
  end

  // Watchdog plus a count of input stalls for the summary.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && hopf_valid && !hopf_ready)
      input_stalls <= input_stalls + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d quaternions outstanding", $time,
               expected_quats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_corner_points();
    int i;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (i = 0; i < CORNER_COUNT; i++)
      send_point(hopf_beat_t'(CORNER_POINTS[i]));
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_random_points(RANDOM_BEATS);
  endtask

  task automatic test_sparse_input();
    send_idle_pct = 82;
    stall_pct     = 0;
    send_random_points(RANDOM_BEATS);
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 0;
    stall_pct     = 82;
    send_random_points(RANDOM_BEATS);
  endtask

  task automatic test_light_gaps();
    send_idle_pct = 8;
    stall_pct     = 8;
    send_random_points(RANDOM_BEATS);
  endtask

  // Output held for a long stretch while input keeps coming: pipeline and
  // skid register fill, hopf_ready must drop and nothing may be lost.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hopf_valid <= 1'b0;   // last beat already taken, keep it from going twice
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_random_points(80);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_corner_points();
    test_full_rate();
    test_sparse_input();
    test_slow_receiver();
    test_light_gaps();
    test_back_pressure();
    hopf_valid <= 1'b0;

    stall_pct = 0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d Hopf points: corners, quadrant edges, random angles,",
             points_sent);
    $display("four gap/stall mixes and a %0d-cycle output hold (%0d input stalls); %0d checked",
             HOLD_CYCLES, input_stalls, quats_checked);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
